/* rtl/bitmap_block_allocator_defines.svh */
// assertion macros shared by the bitmap allocator rtl
`ifndef BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BBA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bitmap allocator check failed");

// next-cycle implication, checked outside reset
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bitmap allocator check failed");

`endif

/* rtl/bba_pkg.sv */
// types, constants and helper functions for the bitmap block allocator
package bba_pkg;

  // capacity and bitmap geometry
  localparam int MAX_BLOCKS  = 8192;
  localparam int WORD_BITS   = 32;
  localparam int NUM_WORDS   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int BLK_IDX_W   = WORD_IDX_W + BIT_IDX_W;
  localparam int NUM_GRP     = WORD_BITS / 8;
  localparam int GRP_IDX_W   = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;

  // field and register widths
  localparam int BLOCK_W     = 13;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 14;
  localparam int CMP_W       = (BLK_IDX_W + 1 > CFG_W) ? BLK_IDX_W + 1 : CFG_W;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic [CFG_W-1:0]      TOTAL_RESET   = CFG_W'(8192);
  localparam logic [WORD_IDX_W-1:0] LAST_WORD     = WORD_IDX_W'(NUM_WORDS - 1);
  localparam logic [0:0]            REG_TOTAL_IDX = 1'b0;

  typedef enum logic [0:0] {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } bba_action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_RANGE       = 2'd3
  } bba_status_t;

  typedef struct packed {
    bba_action_t        action;
    logic [BLOCK_W-1:0] block_number;
  } bba_in_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] allocated_block;
    bba_status_t        status;
  } bba_out_t;

  // bitmap memory access from the engine
  typedef struct packed {
    logic                  rd_en;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [WORD_IDX_W-1:0] wr_addr;
    logic [WORD_BITS-1:0]  wr_data;
  } bba_mem_req_t;

  typedef struct packed {
    logic                 found;
    logic [BIT_IDX_W-1:0] idx;
  } bba_find_t;

  // lowest clear bit of a word: first the byte, then the bit inside it
  function automatic bba_find_t find_zero(logic [WORD_BITS-1:0] w);
    logic [NUM_GRP-1:0]   has_zero;
    logic [GRP_IDX_W-1:0] g;
    logic [7:0]           byte_v;
    logic [2:0]           b;
    bba_find_t            r;
    for (int gi = 0; gi < NUM_GRP; gi++) begin
      has_zero[gi] = ~&w[gi*8 +: 8];
    end
    g = '0;
    for (int gi = NUM_GRP - 1; gi >= 0; gi--) begin
      if (has_zero[gi]) g = GRP_IDX_W'(gi);
    end
    byte_v = w[g*8 +: 8];
    b = '0;
    for (int j = 7; j >= 0; j--) begin
      if (!byte_v[j]) b = 3'(j);
    end
    r.found = |has_zero;
    r.idx   = BIT_IDX_W'({g, b});
    return r;
  endfunction

endpackage

/* rtl/bba_bitmap_ram.sv */
// usage bitmap memory with per-word valid bits so reset frees every block at once
module bba_bitmap_ram
  import bba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  bba_mem_req_t         mem_req,
  output logic [WORD_BITS-1:0] rd_word
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld_r;
  logic [NUM_WORDS-1:0] vld_nxt;
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rvld_r;
  logic                 rvld_nxt;

  // a word becomes valid on its first write
  always_comb begin
    vld_nxt = vld_r;
    if (mem_req.wr_en) vld_nxt[mem_req.wr_addr] = 1'b1;
  end

  always_comb begin
    rvld_nxt = rvld_r;
    if (mem_req.rd_en) rvld_nxt = vld_r[mem_req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      rvld_r <= rvld_nxt;
    end
  end

  // storage array, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) mem[mem_req.wr_addr] <= mem_req.wr_data;
  end

  always_ff @(posedge clk) begin
    if (mem_req.rd_en) rdata_r <= mem[mem_req.rd_addr];
  end

  // never-written words read as all free
  assign rd_word = rvld_r ? rdata_r : '0;

endmodule

/* rtl/bba_engine.sv */
// request sequencer: word scan for allocate, read-modify-write for free
module bba_engine
  import bba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bba_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bba_out_t             out_data,
  input  logic [CFG_W-1:0]     total_blocks,
  output bba_mem_req_t         mem_req,
  input  logic [WORD_BITS-1:0] rd_word
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FREE = 3'b100
  } bba_state_t;

  bba_state_t            state_r, state_nxt;
  logic [BLOCK_W-1:0]    blk_r, blk_nxt;
  logic [CMP_W-1:0]      limit_r, limit_nxt;
  logic [WORD_IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [WORD_IDX_W-1:0] hint_r, hint_nxt;
  logic                  out_valid_r, out_valid_nxt;
  bba_out_t              out_data_r, out_data_nxt;

  logic                  out_free;
  logic [CMP_W-1:0]      total_ext;
  logic [CMP_W-1:0]      in_blk_ext;
  logic [CMP_W-1:0]      blk_ext;
  logic [CMP_W-1:0]      base_ext;
  logic [CMP_W-1:0]      rem;
  logic [WORD_BITS-1:0]  beyond;
  logic [WORD_BITS-1:0]  masked_word;
  logic [WORD_BITS-1:0]  bit_mask;
  logic [WORD_IDX_W-1:0] blk_word;
  bba_find_t             fz;

  assign out_free   = !out_valid_r || out_ready;
  assign total_ext  = CMP_W'(total_blocks);
  assign in_blk_ext = CMP_W'(in_data.block_number);
  assign blk_ext    = CMP_W'(blk_r);
  assign blk_word   = blk_ext[BLK_IDX_W-1:BIT_IDX_W];
  assign bit_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << blk_ext[BIT_IDX_W-1:0];
  assign base_ext   = CMP_W'({scan_idx_r, {BIT_IDX_W{1'b0}}});

  // bits of the current word at or above the block count count as used
  assign rem = limit_r - base_ext;
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      beyond[j] = CMP_W'(j) >= rem;
    end
  end
  assign masked_word = rd_word | beyond;
  assign fz          = find_zero(masked_word);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    blk_nxt       = blk_r;
    limit_nxt     = limit_r;
    scan_idx_nxt  = scan_idx_r;
    hint_nxt      = hint_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_req       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          limit_nxt = (total_ext > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS) : total_ext;
          blk_nxt   = in_data.block_number;
          mem_req.rd_en = 1'b1;
          if (in_data.action == ACT_ALLOC) begin
            mem_req.rd_addr = hint_r;
            scan_idx_nxt    = hint_r;
            state_nxt       = S_SCAN;
          end else begin
            mem_req.rd_addr = in_blk_ext[BLK_IDX_W-1:BIT_IDX_W];
            state_nxt       = S_FREE;
          end
        end
      end
      S_SCAN: begin
        if (base_ext >= limit_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{allocated_block: '0, status: ST_FULL};
            state_nxt     = S_IDLE;
          end
        end else if (fz.found) begin
          if (out_free) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = scan_idx_r;
            mem_req.wr_data = rd_word | ({{(WORD_BITS-1){1'b0}}, 1'b1} << fz.idx);
            out_valid_nxt   = 1'b1;
            out_data_nxt    = '{allocated_block: BLOCK_W'({scan_idx_r, fz.idx}),
                                status: ST_OK};
            state_nxt       = S_IDLE;
          end
        end else begin
          // every word below the hint is completely used
          if ((&rd_word) && (scan_idx_r == hint_r) && (scan_idx_r != LAST_WORD)) begin
            hint_nxt = scan_idx_r + 1'b1;
          end
          if (scan_idx_r == LAST_WORD) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{allocated_block: '0, status: ST_FULL};
              state_nxt     = S_IDLE;
            end
          end else begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = scan_idx_r + 1'b1;
            scan_idx_nxt    = scan_idx_r + 1'b1;
          end
        end
      end
      S_FREE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (blk_ext >= limit_r) begin
            out_data_nxt = '{allocated_block: '0, status: ST_RANGE};
          end else if ((rd_word & bit_mask) == '0) begin
            out_data_nxt = '{allocated_block: '0, status: ST_DOUBLE_FREE};
          end else begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = blk_word;
            mem_req.wr_data = rd_word & ~bit_mask;
            out_data_nxt    = '{allocated_block: '0, status: ST_OK};
            if (blk_word < hint_r) hint_nxt = blk_word;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and per-request registers
  always_ff @(posedge clk) begin
    blk_r      <= blk_nxt;
    limit_r    <= limit_nxt;
    scan_idx_r <= scan_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/bitmap_block_allocator.sv */
// Bitmap free-block allocator: one usage bit per block in a 256 x 32 bit
// memory (bit i in word i/32, position i%32; reset frees every block at once,
// no clearing pass). Requests are handled one at a time. A free does one
// memory read, then check and write back. An allocate reads bitmap words,
// one per cycle over the single read port, starting at the lowest word that
// may hold a free block, and reads at most 256 words. A result held
// in the output register does not block the next input transfer.
// The user must write total_blocks (APB address 0) only while the block is
// idle; the block itself does not enforce it.
module bitmap_block_allocator
  import bba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bba_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bba_out_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

`include "bitmap_block_allocator_defines.svh"

  logic [CFG_W-1:0]     total_r, total_nxt;
  logic                 cfg_wr;
  bba_mem_req_t         mem_req;
  logic [WORD_BITS-1:0] rd_word;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    total_nxt = total_r;
    if (cfg_wr && (paddr[2] == REG_TOTAL_IDX)) total_nxt = pwdata[CFG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
    end else begin
      total_r <= total_nxt;
    end
  end

  assign prdata = (paddr[2] == REG_TOTAL_IDX) ? APB_DATA_W'(total_r) : '0;

  bba_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .total_blocks (total_r),
    .mem_req      (mem_req),
    .rd_word      (rd_word)
  );

  bba_bitmap_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_req (mem_req),
    .rd_word (rd_word)
  );

  // write-back only happens while a request is in flight
  `BBA_ASSERT_IMPL(a_wr_busy, mem_req.wr_en, !in_ready)
  // read and write never share a cycle, so no forwarding is needed
  `BBA_ASSERT_IMPL(a_rd_wr_excl, mem_req.wr_en, !mem_req.rd_en)
  // one request at a time
  `BBA_ASSERT_NEXT(a_one_busy, in_valid && in_ready, !in_ready)
  // a new result only comes from a request in flight
  `BBA_ASSERT_IMPL(a_result_src, $rose(out_valid), $past(!in_ready))

endmodule
